@@ rtl/psg_pkg.sv @@
// Shared types, constants and the envelope step function of the sound generator.
package psg_pkg;

  localparam int ALU_W    = 19;  // shared adder width, signed
  localparam int TC_W     = 17;  // tone counter, signed
  localparam int NC_W     = 18;  // noise and envelope counters, signed
  localparam int NUM_REGS = 14;
  localparam int REG_AW   = 4;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [3:0] REG_NOISE  = 4'd6;
  localparam logic [3:0] REG_MIXER  = 4'd7;
  localparam logic [3:0] REG_VOL_A  = 4'd8;
  localparam logic [3:0] REG_ENV_LO = 4'd11;
  localparam logic [3:0] REG_ENV_HI = 4'd12;
  localparam logic [3:0] REG_SHAPE  = 4'd13;

  localparam logic [7:0]  MIXER_RST       = 8'h3f;
  localparam logic [15:0] TONE_OFF_PERIOD = 16'd32767;
  localparam logic [5:0]  NOISE_DIS_PER   = 6'd62;
  localparam logic [13:0] STEP_RATE_RST   = 14'd1287;
  localparam logic signed [ALU_W-1:0] NOISE_FLOOR = -19'sd65536;

  typedef enum logic [3:0] {
    S_IDLE, S_FRAC, S_TSUB, S_TADD, S_NSUB, S_NADD, S_ESUB, S_EADD, S_DONE
  } state_t;

  typedef struct packed {
    logic neg;
    logic le_zero;
  } alu_flags_t;

  typedef struct packed {
    logic [4:0] level;
    logic       first;
  } env_step_t;

  function automatic env_step_t env_next(input logic [4:0] lvl, input logic [3:0] shape,
                                         input logic first);
    env_step_t r;
    r.level = lvl;
    r.first = first;
    case (shape)
      4'd8:  r.level = lvl - 5'd1;
      4'd9:  if (lvl != 5'd0) r.level = lvl - 5'd1;
      4'd10: begin
        if (first) begin
          if (lvl == 5'd0) r.first = 1'b0; else r.level = lvl - 5'd1;
        end else begin
          if (lvl == 5'd31) r.first = 1'b1; else r.level = lvl + 5'd1;
        end
      end
      4'd11: begin
        if (first) begin
          r.level = lvl - 5'd1;
          r.first = (r.level != 5'd31);
        end
      end
      4'd12: r.level = lvl + 5'd1;
      4'd13: if (lvl != 5'd31) r.level = lvl + 5'd1;
      4'd14: begin
        if (first) begin
          if (lvl == 5'd31) r.first = 1'b0; else r.level = lvl + 5'd1;
        end else begin
          if (lvl == 5'd0) r.first = 1'b1; else r.level = lvl - 5'd1;
        end
      end
      4'd15: begin
        if (first) begin
          r.level = lvl + 5'd1;
          r.first = (r.level != 5'd0);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/psg_alu.sv @@
// Shared signed add/subtract unit with sign and less-or-equal-zero flags.
module psg_alu (
  input  logic signed [psg_pkg::ALU_W-1:0] op_a,
  input  logic signed [psg_pkg::ALU_W-1:0] op_b,
  input  logic                             op_sub,
  output logic signed [psg_pkg::ALU_W-1:0] sum,
  output psg_pkg::alu_flags_t              flags
);

  assign sum           = op_sub ? (op_a - op_b) : (op_a + op_b);
  assign flags.neg     = sum[psg_pkg::ALU_W-1];
  assign flags.le_zero = sum[psg_pkg::ALU_W-1] | (sum == '0);

endmodule

@@ rtl/psg_three_tone_sound_generator.sv @@
// Three-channel sound generator: register file, sequencer and shared adder.
// Register write: taken in the idle state, no result word.
// Register read: result word loaded in the done state once the output slot is free.
// Sample tick: fraction update, tone counter subtract and reload passes per channel, noise and
//   envelope passes, then done; every counter step goes through the one shared adder.
// Reset (synchronous, rst_n low): all state to its documented reset value, no sweep.
module psg_three_tone_sound_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // reg_addr[3:0], reg_data[11:4], zero pad
  input  logic [2:0]  in_tuser,   // cmd[1:0], frame_start[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // chan_a[4:0], chan_b[9:5], chan_c[14:10], read_data[22:15]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data
);

  localparam int W  = psg_pkg::ALU_W;
  localparam int TW = psg_pkg::TC_W;
  localparam int NW = psg_pkg::NC_W;

  psg_pkg::state_t state_r, state_nxt;

  // register file and derived generator state
  logic [7:0]          reg_file_r   [psg_pkg::NUM_REGS];
  logic [7:0]          reg_file_nxt [psg_pkg::NUM_REGS];
  logic [15:0]         tone_period_r [3], tone_period_nxt [3];
  logic signed [TW-1:0] tone_count_r [3], tone_count_nxt [3];
  logic [2:0]          tone_flop_r, tone_flop_nxt;
  logic [2:0]          tone_on_r, tone_on_nxt;
  logic [2:0]          noise_off_r, noise_off_nxt;
  logic [5:0]          noise_period_r, noise_period_nxt;
  logic signed [NW-1:0] noise_count_r, noise_count_nxt;
  logic                noise_bit_r, noise_bit_nxt;
  logic [16:0]         noise_shift_r, noise_shift_nxt;
  logic [15:0]         env_period_r, env_period_nxt;
  logic signed [NW-1:0] env_count_r, env_count_nxt;
  logic [4:0]          env_level_r, env_level_nxt;
  logic                env_first_r, env_first_nxt;
  logic [3:0]          env_shape_r, env_shape_nxt;
  logic [4:0]          chan_vol_r [3], chan_vol_nxt [3];
  logic [2:0]          uses_env_r, uses_env_nxt;
  logic [7:0]          frac_r, frac_nxt;
  logic [13:0]         step_rate_r;

  // sequencer working registers
  logic [6:0]          steps_r, steps_nxt;
  logic [1:0]          ch_r, ch_nxt;
  logic                is_read_r;
  logic                frame_r;
  logic [3:0]          addr_r;

  logic                out_tvalid_r;
  logic [23:0]         out_tdata_r, out_tdata_nxt;
  logic                load_out;

  // shared adder
  logic signed [W-1:0] alu_a, alu_b, alu_sum;
  logic                alu_sub;
  psg_pkg::alu_flags_t alu_flags;

  psg_alu u_alu (
    .op_a   (alu_a),
    .op_b   (alu_b),
    .op_sub (alu_sub),
    .sum    (alu_sum),
    .flags  (alu_flags)
  );

  logic       in_acc;
  logic [1:0] in_cmd;
  logic [3:0] in_addr;
  logic [7:0] in_data;

  assign in_cmd   = in_tuser[1:0];
  assign in_addr  = in_tdata[3:0];
  assign in_data  = in_tdata[11:4];
  assign in_acc   = in_tvalid && in_tready;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psg_pkg::S_IDLE: begin
        if (in_acc && in_cmd == psg_pkg::CMD_READ) state_nxt = psg_pkg::S_DONE;
        else if (in_acc && in_cmd == psg_pkg::CMD_TICK) state_nxt = psg_pkg::S_FRAC;
      end
      psg_pkg::S_FRAC: state_nxt = psg_pkg::S_TSUB;
      psg_pkg::S_TSUB: begin
        if (alu_flags.le_zero) state_nxt = psg_pkg::S_TADD;
        else if (ch_r == 2'd2) state_nxt = psg_pkg::S_NSUB;
      end
      psg_pkg::S_TADD: begin
        if (!alu_flags.neg) state_nxt = (ch_r == 2'd2) ? psg_pkg::S_NSUB : psg_pkg::S_TSUB;
      end
      psg_pkg::S_NSUB: state_nxt = alu_flags.le_zero ? psg_pkg::S_NADD : psg_pkg::S_ESUB;
      psg_pkg::S_NADD: state_nxt = psg_pkg::S_ESUB;
      psg_pkg::S_ESUB: state_nxt = alu_flags.le_zero ? psg_pkg::S_EADD : psg_pkg::S_DONE;
      psg_pkg::S_EADD: if (!alu_flags.neg) state_nxt = psg_pkg::S_DONE;
      psg_pkg::S_DONE: if (load_out) state_nxt = psg_pkg::S_IDLE;
      default: state_nxt = psg_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and adder operand select
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b1;
    case (state_r)
      psg_pkg::S_IDLE: in_tready = 1'b1;
      psg_pkg::S_FRAC: begin
        alu_a   = frame_r ? '0 : {{(W-8){1'b0}}, frac_r};
        alu_b   = {{(W-14){1'b0}}, step_rate_r};
        alu_sub = 1'b0;
      end
      psg_pkg::S_TSUB: begin
        alu_a = {{(W-TW){tone_count_r[ch_r][TW-1]}}, tone_count_r[ch_r]};
        alu_b = {{(W-7){1'b0}}, steps_r};
      end
      psg_pkg::S_TADD: begin
        alu_a   = {{(W-TW){tone_count_r[ch_r][TW-1]}}, tone_count_r[ch_r]};
        alu_b   = {{(W-16){1'b0}}, tone_period_r[ch_r]};
        alu_sub = 1'b0;
      end
      psg_pkg::S_NSUB: begin
        alu_a = {{(W-NW){noise_count_r[NW-1]}}, noise_count_r};
        alu_b = {{(W-7){1'b0}}, steps_r};
      end
      psg_pkg::S_NADD: begin
        alu_a   = {{(W-NW){noise_count_r[NW-1]}}, noise_count_r};
        alu_b   = {{(W-6){1'b0}}, noise_period_r};
        alu_sub = 1'b0;
      end
      psg_pkg::S_ESUB: begin
        alu_a = {{(W-NW){env_count_r[NW-1]}}, env_count_r};
        alu_b = {{(W-7){1'b0}}, steps_r};
      end
      psg_pkg::S_EADD: begin
        alu_a   = {{(W-NW){env_count_r[NW-1]}}, env_count_r};
        alu_b   = {{(W-16){1'b0}}, env_period_r};
        alu_sub = 1'b0;
      end
      psg_pkg::S_DONE: load_out = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    logic                wr;
    logic [7:0]          lo, hi;
    logic [15:0]         per16, ecur;
    logic signed [W-1:0] tc;
    logic [5:0]          np;
    logic [3:0]          shp;
    logic [4:0]          lvl [3];
    logic [7:0]          rd;
    psg_pkg::env_step_t  es;

    lo    = '0;
    hi    = '0;
    per16 = '0;
    ecur  = '0;
    tc    = '0;
    np    = '0;
    shp   = '0;
    for (int i = 0; i < psg_pkg::NUM_REGS; i++) reg_file_nxt[i] = reg_file_r[i];
    for (int c = 0; c < 3; c++) begin
      tone_period_nxt[c] = tone_period_r[c];
      tone_count_nxt[c]  = tone_count_r[c];
      chan_vol_nxt[c]    = chan_vol_r[c];
    end
    tone_flop_nxt    = tone_flop_r;
    tone_on_nxt      = tone_on_r;
    noise_off_nxt    = noise_off_r;
    noise_period_nxt = noise_period_r;
    noise_count_nxt  = noise_count_r;
    noise_bit_nxt    = noise_bit_r;
    noise_shift_nxt  = noise_shift_r;
    env_period_nxt   = env_period_r;
    env_count_nxt    = env_count_r;
    env_level_nxt    = env_level_r;
    env_first_nxt    = env_first_r;
    env_shape_nxt    = env_shape_r;
    uses_env_nxt     = uses_env_r;
    frac_nxt         = frac_r;
    steps_nxt        = steps_r;
    ch_nxt           = ch_r;
    out_tdata_nxt    = out_tdata_r;
    es               = psg_pkg::env_next(env_level_r, env_shape_r, env_first_r);

    wr = in_acc && (in_cmd == psg_pkg::CMD_WRITE)
         && (in_addr < 4'(psg_pkg::NUM_REGS));
    if (wr) reg_file_nxt[in_addr] = in_data;

    // tone period writes
    for (int c = 0; c < 3; c++) begin
      if (wr && (in_addr[3:1] == 3'(c))) begin
        lo    = in_addr[0] ? reg_file_r[2*c] : in_data;
        hi    = in_addr[0] ? in_data : reg_file_r[2*c+1];
        per16 = {4'd0, hi[3:0], lo};
        if (per16 == 16'd0) per16 = 16'd1;
        tc = {{(W-TW){tone_count_r[c][TW-1]}}, tone_count_r[c]}
             + $signed({3'b000, per16}) - $signed({3'b000, tone_period_r[c]});
        tone_count_nxt[c]  = tc[W-1] ? TW'(1) : tc[TW-1:0];
        tone_period_nxt[c] = per16;
      end
    end

    if (wr && in_addr == psg_pkg::REG_NOISE) begin
      np = {in_data[4:0], 1'b0};
      if (np != noise_period_r) begin
        noise_period_nxt = np;
        noise_count_nxt  = {{(NW-6){1'b0}}, np};
      end
    end

    if (wr && in_addr == psg_pkg::REG_MIXER) begin
      for (int c = 0; c < 3; c++) begin
        tone_on_nxt[c]   = !in_data[c];
        noise_off_nxt[c] = in_data[c+3];
        if (in_data[c]) begin
          tone_period_nxt[c] = psg_pkg::TONE_OFF_PERIOD;
          tone_flop_nxt[c]   = 1'b1;
        end
      end
      if (&in_data[5:3]) noise_period_nxt = psg_pkg::NOISE_DIS_PER;
    end

    for (int c = 0; c < 3; c++) begin
      if (wr && in_addr == psg_pkg::REG_VOL_A + 4'(c)) begin
        uses_env_nxt[c] = in_data[4];
        chan_vol_nxt[c] = in_data[4] ? env_level_r : {in_data[3:0], 1'b1};
      end
    end

    if (wr && (in_addr == psg_pkg::REG_ENV_LO || in_addr == psg_pkg::REG_ENV_HI)) begin
      lo    = (in_addr == psg_pkg::REG_ENV_LO) ? in_data : reg_file_r[psg_pkg::REG_ENV_LO];
      hi    = (in_addr == psg_pkg::REG_ENV_HI) ? in_data : reg_file_r[psg_pkg::REG_ENV_HI];
      per16 = {hi, lo};
      if (per16 == 16'd0) per16 = 16'd1;
      ecur  = (uses_env_r == 3'b000) ? psg_pkg::TONE_OFF_PERIOD : env_period_r;
      env_period_nxt = ecur;
      if (per16 != ecur) begin
        env_period_nxt = per16;
        env_count_nxt  = {{(NW-16){1'b0}}, per16};
        env_first_nxt  = 1'b1;
      end
    end

    if (wr && in_addr == psg_pkg::REG_SHAPE) begin
      shp = in_data[3:0];
      if (shp < 4'd4) shp = 4'd9;
      else if (shp < 4'd8) shp = 4'd15;
      env_shape_nxt = shp;
      env_level_nxt = (shp < 4'd12) ? 5'd31 : 5'd0;
      env_first_nxt = 1'b1;
      for (int c = 0; c < 3; c++) if (uses_env_r[c]) chan_vol_nxt[c] = env_level_nxt;
    end

    // tick sequence
    case (state_r)
      psg_pkg::S_FRAC: begin
        steps_nxt = alu_sum[14:8];
        frac_nxt  = alu_sum[7:0];
        ch_nxt    = 2'd0;
      end
      psg_pkg::S_TSUB: begin
        tone_count_nxt[ch_r] = alu_sum[TW-1:0];
        if (!alu_flags.le_zero) ch_nxt = (ch_r == 2'd2) ? 2'd0 : ch_r + 2'd1;
      end
      psg_pkg::S_TADD: begin
        tone_count_nxt[ch_r] = alu_sum[TW-1:0];
        if (tone_on_r[ch_r]) tone_flop_nxt[ch_r] = !tone_flop_r[ch_r];
        if (!alu_flags.neg) ch_nxt = (ch_r == 2'd2) ? 2'd0 : ch_r + 2'd1;
      end
      psg_pkg::S_NSUB: noise_count_nxt = alu_sum[NW-1:0];
      psg_pkg::S_NADD: begin
        noise_bit_nxt   = noise_shift_r[0];
        noise_shift_nxt = {noise_shift_r[0] ^ noise_shift_r[3], noise_shift_r[16:1]};
        noise_count_nxt = (alu_sum < psg_pkg::NOISE_FLOOR) ? psg_pkg::NOISE_FLOOR[NW-1:0]
                                                           : alu_sum[NW-1:0];
      end
      psg_pkg::S_ESUB: env_count_nxt = alu_sum[NW-1:0];
      psg_pkg::S_EADD: begin
        env_count_nxt = alu_sum[NW-1:0];
        env_level_nxt = es.level;
        env_first_nxt = es.first;
        for (int c = 0; c < 3; c++) if (uses_env_r[c]) chan_vol_nxt[c] = es.level;
      end
      default: ;
    endcase

    // result word
    for (int c = 0; c < 3; c++) begin
      lvl[c] = ((noise_bit_r || noise_off_r[c]) && tone_flop_r[c] && !is_read_r)
               ? chan_vol_r[c] : 5'd0;
    end
    rd = '0;
    if (is_read_r && addr_r < 4'(psg_pkg::NUM_REGS)) rd = reg_file_r[addr_r];
    if (load_out) out_tdata_nxt = {1'b0, rd, lvl[2], lvl[1], lvl[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psg_pkg::S_IDLE;
      for (int i = 0; i < psg_pkg::NUM_REGS; i++)
        reg_file_r[i] <= (i == int'(psg_pkg::REG_MIXER)) ? psg_pkg::MIXER_RST : 8'd0;
      for (int c = 0; c < 3; c++) begin
        tone_period_r[c] <= psg_pkg::TONE_OFF_PERIOD;
        tone_count_r[c]  <= '0;
        chan_vol_r[c]    <= 5'd1;
      end
      tone_flop_r    <= 3'b000;
      tone_on_r      <= 3'b000;
      noise_off_r    <= 3'b111;
      noise_period_r <= psg_pkg::NOISE_DIS_PER;
      noise_count_r  <= '0;
      noise_bit_r    <= 1'b0;
      noise_shift_r  <= 17'd1;
      env_period_r   <= 16'd1;
      env_count_r    <= NW'(1);
      env_level_r    <= 5'd31;
      env_first_r    <= 1'b1;
      env_shape_r    <= 4'd9;
      uses_env_r     <= 3'b000;
      frac_r         <= 8'd0;
      step_rate_r    <= psg_pkg::STEP_RATE_RST;
      steps_r        <= '0;
      ch_r           <= 2'd0;
      is_read_r      <= 1'b0;
      frame_r        <= 1'b0;
      addr_r         <= '0;
      out_tvalid_r   <= 1'b0;
      out_tdata_r    <= '0;
    end else begin
      state_r <= state_nxt;
      for (int i = 0; i < psg_pkg::NUM_REGS; i++) reg_file_r[i] <= reg_file_nxt[i];
      for (int c = 0; c < 3; c++) begin
        tone_period_r[c] <= tone_period_nxt[c];
        tone_count_r[c]  <= tone_count_nxt[c];
        chan_vol_r[c]    <= chan_vol_nxt[c];
      end
      tone_flop_r    <= tone_flop_nxt;
      tone_on_r      <= tone_on_nxt;
      noise_off_r    <= noise_off_nxt;
      noise_period_r <= noise_period_nxt;
      noise_count_r  <= noise_count_nxt;
      noise_bit_r    <= noise_bit_nxt;
      noise_shift_r  <= noise_shift_nxt;
      env_period_r   <= env_period_nxt;
      env_count_r    <= env_count_nxt;
      env_level_r    <= env_level_nxt;
      env_first_r    <= env_first_nxt;
      env_shape_r    <= env_shape_nxt;
      uses_env_r     <= uses_env_nxt;
      frac_r         <= frac_nxt;
      steps_r        <= steps_nxt;
      ch_r           <= ch_nxt;
      if (cfg_valid && cfg_ready) step_rate_r <= cfg_data;
      if (in_acc) begin
        is_read_r <= (in_cmd == psg_pkg::CMD_READ);
        frame_r   <= in_tuser[2];
        addr_r    <= in_addr;
      end
      if (load_out) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      out_tdata_r <= out_tdata_nxt;
    end
  end

  // a finished result always finds its way into a free output slot
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psg_pkg::S_DONE && !out_tvalid_r) |=> out_tvalid_r)
    else $error("result not loaded from done state");

  // tone channel pointer stays on a real channel
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n) ch_r != 2'd3)
    else $error("tone channel pointer out of range");

  // a tick starts the step fraction update right away
  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == psg_pkg::CMD_TICK) |=> state_r == psg_pkg::S_FRAC)
    else $error("tick did not start sequencer");

  // noise counter is clamped at its floor once the reload pass has run
  a_noise_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != psg_pkg::S_NADD) |->
      ($signed({{(W-NW){noise_count_r[NW-1]}}, noise_count_r}) >= psg_pkg::NOISE_FLOOR))
    else $error("noise counter below floor");

  // envelope reload period never zero, else the reload loop would not end
  a_env_period: assert property (@(posedge clk) disable iff (!rst_n) env_period_r != 16'd0)
    else $error("envelope period zero");

endmodule
